[rtl/i2ra_pkg.sv]
// Shared types, constants and helper functions for the integer to radix ASCII unit.
// No dependencies; every other file in rtl/ imports this package.
package i2ra_pkg;

    localparam int VALUE_BITS = 64;

    function automatic int dec_digits(int bits);
        logic [63:0] m;
        int          n;
        m = (bits >= 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
        n = 0;
        for (int i = 0; i < 20; i++) begin
            if (m != 64'd0) begin
                m = m / 10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int SLOTS      = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;
    localparam int EXT_W      = 4 * SLOTS;
    localparam int LEFT_W     = $clog2(SLOTS + 1);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ALPHA = 7'h37;
    localparam logic [6:0] CH_MINUS = 7'h2d;

    typedef struct packed {
        logic [63:0] value;
        logic        is_signed;
    } t_in_item;

    typedef struct packed {
        logic [6:0] char_out;
        logic       last_char;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic shift;
    } t_dsr_ctrl;

    typedef struct packed {
        logic [3:0] digit;
        logic       last;
    } t_dsr_stat;

    function automatic logic [6:0] digit_char(logic [3:0] d);
        return (d > 4'd9) ? (CH_ALPHA + {3'd0, d}) : (CH_ZERO + {3'd0, d});
    endfunction

endpackage

[rtl/i2ra_bcd_conv.sv]
// Binary to BCD converter: shift-and-add-3, one magnitude bit per cycle.
// Depends on i2ra_pkg.
module i2ra_bcd_conv
    import i2ra_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [VALUE_BITS-1:0]     i_mag,
    output logic                      o_done,
    output logic [4*DEC_DIGITS-1:0]   o_bcd
);

    logic [4*DEC_DIGITS-1:0] r_bcd;
    logic [4*DEC_DIGITS-1:0] n_bcd;
    logic [4*DEC_DIGITS-1:0] w_adj;
    logic [VALUE_BITS-1:0]   r_sh;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;

    always_comb begin
        for (int k = 0; k < DEC_DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? (r_bcd[4*k +: 4] + 4'd3)
                                                        : r_bcd[4*k +: 4];
        end
        n_bcd = {w_adj[4*DEC_DIGITS-2:0], r_sh[VALUE_BITS-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bcd <= '0;
            r_sh  <= i_mag;
        end else if (r_busy) begin
            r_bcd <= n_bcd;
            r_sh  <= {r_sh[VALUE_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

[rtl/i2ra_digit_shift.sv]
// Digit shift register: holds digits most significant at the top, shifts one digit per step.
// Depends on i2ra_pkg.
module i2ra_digit_shift
    import i2ra_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dsr_ctrl                 i_ctrl,
    input  logic [1:0]                i_radix,
    input  logic [VALUE_BITS-1:0]     i_mag,
    input  logic [4*DEC_DIGITS-1:0]   i_bcd,
    output t_dsr_stat                 o_stat
);

    logic [3:0]        r_slot [SLOTS];
    logic [3:0]        n_slot [SLOTS];
    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;
    logic [EXT_W-1:0]  w_ext;

    assign w_ext = {{(EXT_W - VALUE_BITS){1'b0}}, i_mag};

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            n_slot[j] = 4'd0;
        end
        unique case (i_radix)
            RADIX_OCT: begin
                n_left = LEFT_W'(OCT_DIGITS);
                for (int k = 0; k < OCT_DIGITS; k++) begin
                    n_slot[SLOTS - OCT_DIGITS + k] = {1'b0, w_ext[3*k +: 3]};
                end
            end
            RADIX_HEX: begin
                n_left = LEFT_W'(HEX_DIGITS);
                for (int k = 0; k < HEX_DIGITS; k++) begin
                    n_slot[SLOTS - HEX_DIGITS + k] = w_ext[4*k +: 4];
                end
            end
            default: begin
                n_left = LEFT_W'(DEC_DIGITS);
                for (int k = 0; k < DEC_DIGITS; k++) begin
                    n_slot[SLOTS - DEC_DIGITS + k] = i_bcd[4*k +: 4];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_ctrl.load) begin
            r_left <= n_left;
        end else if (i_ctrl.shift) begin
            r_left <= r_left - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_slot <= n_slot;
        end else if (i_ctrl.shift) begin
            r_slot[0] <= 4'd0;
            for (int j = 1; j < SLOTS; j++) begin
                r_slot[j] <= r_slot[j-1];
            end
        end
    end

    assign o_stat.digit = r_slot[SLOTS-1];
    assign o_stat.last  = (r_left == LEFT_W'(1));

endmodule

[rtl/int64_to_radix_ascii_unit.sv]
// Top level of the integer to radix ASCII unit: control sequencer, config and output register.
// Depends on i2ra_pkg, i2ra_bcd_conv and i2ra_digit_shift.
//
// Converts one VALUE_BITS-wide value per item into ASCII characters, most significant digit
// first, one output item per character, last_char set on the final one; a signed negative
// value is preceded by '-'. radix_mode selects decimal (0, also 3), octal (1) or upper-case
// hex (2). One item is worked on at a time: input stall stays high from acceptance until the
// final character is in the output register. After acceptance a prepare step starts the work;
// decimal then runs shift-and-add-3 conversion, one magnitude bit per cycle, while octal and
// hex load their digits directly. Then come the sign slot (taken whether or not '-' is sent),
// the skip over leading zero digit slots, the step that leaves the zero skip and one step per
// digit emitted; output stall holds the '-' and digit steps until the output register is free.
module int64_to_radix_ascii_unit
    import i2ra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_CONV = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_SKIP = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [1:0]              r_radix;
    logic [VALUE_BITS-1:0]   r_mag;
    logic                    r_neg;
    logic                    r_out_valid;
    t_out_item               r_out_item;

    logic                    w_accept;
    logic                    w_out_free;
    logic [VALUE_BITS-1:0]   w_raw;
    logic                    w_neg;
    logic                    w_is_dec;
    logic                    w_conv_start;
    logic                    w_conv_done;
    logic [4*DEC_DIGITS-1:0] w_bcd;
    logic                    w_out_load;
    t_out_item               w_out_next;
    t_dsr_ctrl               w_dsr_ctrl;
    t_dsr_stat               w_dsr_stat;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_raw      = i_in_item.value[VALUE_BITS-1:0];
    assign w_neg      = i_in_item.is_signed && w_raw[VALUE_BITS-1];
    assign w_is_dec   = (r_radix != RADIX_OCT) && (r_radix != RADIX_HEX);

    always_comb begin
        n_state           = r_state;
        w_conv_start      = 1'b0;
        w_dsr_ctrl        = '0;
        w_out_load        = 1'b0;
        w_out_next        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (w_is_dec) begin
                    w_conv_start = 1'b1;
                    n_state      = S_CONV;
                end else begin
                    w_dsr_ctrl.load = 1'b1;
                    n_state         = S_SIGN;
                end
            end
            S_CONV: begin
                if (w_conv_done) begin
                    w_dsr_ctrl.load = 1'b1;
                    n_state         = S_SIGN;
                end
            end
            S_SIGN: begin
                if (!r_neg) begin
                    n_state = S_SKIP;
                end else if (w_out_free) begin
                    w_out_load           = 1'b1;
                    w_out_next.char_out  = CH_MINUS;
                    w_out_next.last_char = 1'b0;
                    n_state              = S_SKIP;
                end
            end
            S_SKIP: begin
                if ((w_dsr_stat.digit == 4'd0) && !w_dsr_stat.last) begin
                    w_dsr_ctrl.shift = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load           = 1'b1;
                    w_out_next.char_out  = digit_char(w_dsr_stat.digit);
                    w_out_next.last_char = w_dsr_stat.last;
                    if (w_dsr_stat.last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_dsr_ctrl.shift = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_DEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_neg;
            r_mag <= w_neg ? (~w_raw + VALUE_BITS'(1)) : w_raw;
        end
        if (w_out_load) begin
            r_out_item <= w_out_next;
        end
    end

    i2ra_bcd_conv u_bcd_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_conv_start),
        .i_mag   (r_mag),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    i2ra_digit_shift u_digit_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_dsr_ctrl),
        .i_radix (r_radix),
        .i_mag   (r_mag),
        .i_bcd   (w_bcd),
        .o_stat  (w_dsr_stat)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.char_out == CH_MINUS)) |-> !o_out_item.last_char)
        else $error("minus sign marked as last character");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled while an item is in work");

    a_conv_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_done |-> (r_state == S_CONV))
        else $error("decimal conversion finished outside its phase");
`endif

endmodule

[verif/ascii_digit_checker.sv]
// Checker for int64_to_radix_ascii_unit: tracks radix_mode, predicts the ASCII characters of
// every accepted value and compares each accepted output item against them in order.
// Depends on i2ra_pkg for the item types, radix codes and character constants.
module ascii_digit_checker
    import i2ra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_stall,
    input  t_in_item   in_item,
    input  logic       out_valid,
    input  logic       out_stall,
    input  t_out_item  out_item,
    output int         mismatches,
    output int         pending,
    output int         chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_CHARS  = 23;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

    logic [1:0] radix;
    t_out_item  expected_chars [$];

    task automatic queue_digits(input t_in_item it);
        logic [63:0] mag;
        logic [6:0]  digit_buf [MAX_CHARS];
        logic [3:0]  d;
        logic        neg;
        int          nd;
        t_out_item   ch;
        mag = it.value & VALUE_MASK;
        neg = it.is_signed && mag[VALUE_BITS-1];
        nd  = 0;
        if (neg) begin
            mag = (-mag) & VALUE_MASK;
        end
        while (mag != 64'd0 && nd < MAX_CHARS) begin
            case (radix)
                RADIX_OCT: begin
                    d   = 4'(mag & 64'd7);
                    mag = mag >> 3;
                end
                RADIX_HEX: begin
                    d   = 4'(mag & 64'd15);
                    mag = mag >> 4;
                end
                default: begin
                    d   = 4'(mag % 64'd10);
                    mag = mag / 64'd10;
                end
            endcase
            digit_buf[nd] = (d > 4'd9) ? (CH_ALPHA + 7'(d)) : (CH_ZERO + 7'(d));
            nd++;
        end
        if (nd == 0) begin
            digit_buf[0] = CH_ZERO;
            nd = 1;
        end
        if (neg) begin
            ch.char_out  = CH_MINUS;
            ch.last_char = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            ch.char_out  = digit_buf[i];
            ch.last_char = (i == 0);
            expected_chars.push_back(ch);
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            radix         = RADIX_DEC;
            mismatches    = 0;
            chars_checked = 0;
            expected_chars.delete();
        end else begin
            if (out_valid && !out_stall) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected item char_out 0x%02h last_char %0b", $time,
                             out_item.char_out, out_item.last_char);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.char_out !== out_item.char_out) begin
                        $display("%0t: char_out expected 0x%02h actual 0x%02h", $time,
                                 want.char_out, out_item.char_out);
                        mismatches++;
                    end
                    if (want.last_char !== out_item.last_char) begin
                        $display("%0t: last_char expected %0b actual %0b", $time,
                                 want.last_char, out_item.last_char);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                queue_digits(in_item);
            end
            if (cfg_we) begin
                radix = cfg_wdata;
            end
        end
        pending = expected_chars.size();
    end

endmodule

[verif/int64_to_radix_ascii_unit_tb.sv]
// Top of the int64_to_radix_ascii_unit testbench: clock, reset, value stimulus, output stalls,
// radix_mode writes, watchdog and verdict. Depends on i2ra_pkg, the unit and ascii_digit_checker.
module int64_to_radix_ascii_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i2ra_pkg::*;

    localparam logic [1:0] RADIX_UNUSED   = 2'd3;
    localparam int         MAX_GAP        = 19;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         DRAIN_CYCLES   = 120;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_VALUES   = 34;
    localparam logic [63:0] ALL_ONES      = {64{1'b1}};
    localparam logic [63:0] TOP_BIT       = 64'h8000_0000_0000_0000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_wdata = RADIX_DEC;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;

    int mismatches;
    int pending;
    int chars_checked;
    int tx_max       = MAX_GAP;
    int rx_max       = MAX_GAP;
    bit hold_long    = 1'b0;
    int values_sent  = 0;
    int negatives    = 0;
    int idle_cycles  = 0;

    logic [1:0] phase_radix [4] = '{RADIX_HEX, RADIX_DEC, RADIX_OCT, RADIX_UNUSED};

    int64_to_radix_ascii_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    ascii_digit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item),
        .mismatches    (mismatches),
        .pending       (pending),
        .chars_checked (chars_checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] draw_value();
        logic [63:0] v;
        logic [63:0] p;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            1: v = v >> $urandom_range(1, 63);
            2: v = 64'($urandom_range(0, 40));
            3: v = -64'($urandom_range(1, 40));
            4: v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
            5: begin
                p = 64'd1;
                repeat ($urandom_range(1, 19)) p = p * 64'd10;
                v = p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [63:0] v, input logic s);
        int gap;
        gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_item.value     <= v;
        in_item.is_signed <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        values_sent++;
        if (s && v[VALUE_BITS-1]) begin
            negatives++;
        end
    endtask

    // drop valid, drain every pending character, then write radix_mode
    task automatic set_radix(input logic [1:0] r);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int n;
        forever begin
            if (hold_long) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
            end
            n = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("int64_to_radix_ascii_unit_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_value(64'd0, 1'b0);
        send_value(64'd0, 1'b1);
        send_value(ALL_ONES, 1'b0);
        send_value(ALL_ONES, 1'b1);
        send_value(TOP_BIT, 1'b1);
        send_value(TOP_BIT, 1'b0);
        send_value(~TOP_BIT, 1'b1);
        send_value(64'd1, 1'b0);
        send_value(64'd9, 1'b1);
        send_value(64'd10, 1'b0);

        set_radix(RADIX_OCT);
        send_value(ALL_ONES, 1'b0);
        send_value(TOP_BIT, 1'b1);
        send_value(64'd7, 1'b0);
        send_value(64'd8, 1'b1);
        send_value(64'd0, 1'b0);

        set_radix(RADIX_HEX);
        send_value(ALL_ONES, 1'b0);
        send_value(64'hFEDC_BA98_7654_3210, 1'b0);
        send_value(64'h0123_4567_89AB_CDEF, 1'b1);
        send_value(64'hA, 1'b0);
        send_value(-64'd10, 1'b1);

        set_radix(RADIX_UNUSED);
        send_value(64'd12345, 1'b0);
        send_value(-64'd12345, 1'b1);
        send_value(ALL_ONES, 1'b0);

        for (int p = 0; p < 4; p++) begin
            set_radix(phase_radix[p]);
            tx_max = (p == 1) ? 0 : MAX_GAP;
            rx_max = (p == 2) ? 0 : MAX_GAP;
            if (p == 1) begin
                hold_long = 1'b1;
            end
            for (int k = 0; k < PHASE_VALUES; k++) begin
                send_value(draw_value(), 1'($urandom_range(0, 1)));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values (%0d negative signed) into %0d checked characters",
                 values_sent, negatives, chars_checked);
        $display("Radix codes 0 to 3 all exercised, with a long output hold backing up input");
        if (mismatches == 0 && pending == 0) begin
            $display("int64_to_radix_ascii_unit_tb OK");
        end else begin
            $display("int64_to_radix_ascii_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
